[rtl/core/cmir_pkg.sv]
// Package for the colour matrix inverse block.
// Holds widths, limits, status codes and the queue entry type.
// No dependencies.
package cmir_pkg;

    localparam int FRAC_BITS      = 24;
    localparam int NUM_ELEM       = 9;
    localparam int IDX_W          = 4;
    localparam int M_W            = 32;
    localparam int ADJ_W          = 2 * M_W + 1;
    localparam int AMAG_W         = 2 * M_W;
    localparam int DET_W          = M_W + ADJ_W + 2;
    localparam int DMAG_W         = DET_W - 1;
    localparam int SCALE_W        = 24;
    localparam int SADJ_W         = AMAG_W + SCALE_W;
    localparam int DIV_W          = DMAG_W + 33;
    localparam int Q_W            = 32;
    localparam int INV_LIMIT_LOG2 = 7;
    localparam int CMP_W          = DMAG_W + INV_LIMIT_LOG2;

    localparam logic [SCALE_W-1:0] DENOM_SCALE = 24'd10000000;

    // |det| * 1e12 <= 2^(3F)  <=>  |det| <= floor(2^(3F) / 1e12)
    localparam logic [127:0] SING_LIM =
        (128'd1 << (3 * FRAC_BITS)) / 128'd1000000000000;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_SINGULAR = 2'd1,
        STS_RANGE    = 2'd2
    } cmir_status_t;

    typedef struct packed {
        logic [NUM_ELEM-1:0][M_W-1:0]    m;
        logic [NUM_ELEM-1:0][AMAG_W-1:0] adj_mag;
        logic [NUM_ELEM-1:0]             adj_neg;
        logic [DMAG_W-1:0]               det_mag;
        logic                            det_neg;
        cmir_status_t                    status;
    } cmir_item_t;

endpackage

[rtl/core/cmir_front.sv]
// Front pipeline: cofactors, determinant and classification.
// Depends on cmir_pkg; feeds cmir_fifo.
module cmir_front import cmir_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [NUM_ELEM-1:0][M_W-1:0]    mat_in,
    input  logic                            q_full,
    output logic                            push,
    output cmir_item_t                      item
);

    localparam int TA [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int TB [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int TC [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int TD [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
    localparam int NSTG = 8;
    localparam int PP_W = M_W + 33;

    logic [NSTG-1:0] v_reg, v_next;
    logic            adv;

    logic signed [M_W-1:0]    m1_reg [NUM_ELEM];
    logic signed [M_W-1:0]    m2_reg [NUM_ELEM];
    logic signed [M_W-1:0]    m3_reg [NUM_ELEM];
    logic signed [M_W-1:0]    m4_reg [NUM_ELEM];
    logic signed [M_W-1:0]    m5_reg [NUM_ELEM];
    logic signed [M_W-1:0]    m6_reg [NUM_ELEM];
    logic signed [M_W-1:0]    m7_reg [NUM_ELEM];
    logic signed [M_W-1:0]    m8_reg [NUM_ELEM];
    logic signed [2*M_W-1:0]  ppa_reg [NUM_ELEM];
    logic signed [2*M_W-1:0]  ppc_reg [NUM_ELEM];
    logic signed [ADJ_W-1:0]  adj3_reg [NUM_ELEM];
    logic signed [ADJ_W-1:0]  adj4_reg [NUM_ELEM];
    logic signed [ADJ_W-1:0]  adj5_reg [NUM_ELEM];
    logic signed [ADJ_W-1:0]  adj6_reg [NUM_ELEM];
    logic signed [PP_W-1:0]   plo_reg [3];
    logic signed [PP_W-1:0]   phi_reg [3];
    logic signed [DET_W-1:0]  term_reg [3];
    logic signed [DET_W-1:0]  det6_reg;
    logic [AMAG_W-1:0]        amag7_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0]      aneg7_reg;
    logic [DMAG_W-1:0]        dmag7_reg;
    logic                     dneg7_reg;
    logic [AMAG_W-1:0]        amag8_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0]      aneg8_reg;
    logic [DMAG_W-1:0]        dmag8_reg;
    logic                     dneg8_reg;
    cmir_status_t             sts8_reg;

    logic signed [DET_W-1:0]  det_abs;
    logic                     sing;
    logic                     range_hit;

    assign adv      = !v_reg[NSTG-1] || !q_full;
    assign in_ready = adv;
    assign push     = v_reg[NSTG-1] && adv;
    assign v_next   = adv ? {v_reg[NSTG-2:0], in_valid} : v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign det_abs = det6_reg[DET_W-1] ? -det6_reg : det6_reg;

    always_comb
    begin
        sing      = {{(128-DMAG_W){1'b0}}, dmag7_reg} <= SING_LIM;
        range_hit = 1'b0;
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            if ((CMP_W'(amag7_reg[k]) << FRAC_BITS) >
                (CMP_W'(dmag7_reg) << INV_LIMIT_LOG2))
            begin
                range_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                m1_reg[k]   <= $signed(mat_in[k]);
                m2_reg[k]   <= m1_reg[k];
                m3_reg[k]   <= m2_reg[k];
                m4_reg[k]   <= m3_reg[k];
                m5_reg[k]   <= m4_reg[k];
                m6_reg[k]   <= m5_reg[k];
                m7_reg[k]   <= m6_reg[k];
                m8_reg[k]   <= m7_reg[k];
                ppa_reg[k]  <= m1_reg[TA[k]] * m1_reg[TB[k]];
                ppc_reg[k]  <= m1_reg[TC[k]] * m1_reg[TD[k]];
                adj3_reg[k] <= ADJ_W'(ppa_reg[k]) - ADJ_W'(ppc_reg[k]);
                adj4_reg[k] <= adj3_reg[k];
                adj5_reg[k] <= adj4_reg[k];
                adj6_reg[k] <= adj5_reg[k];
                aneg7_reg[k] <= adj6_reg[k][ADJ_W-1];
                amag7_reg[k] <= adj6_reg[k][ADJ_W-1] ? AMAG_W'(-adj6_reg[k])
                                                     : AMAG_W'(adj6_reg[k]);
                amag8_reg[k] <= amag7_reg[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                plo_reg[k]  <= m3_reg[k] * $signed({1'b0, adj3_reg[3*k][M_W-1:0]});
                phi_reg[k]  <= m3_reg[k] * $signed(adj3_reg[3*k][ADJ_W-1:M_W]);
                term_reg[k] <= (DET_W'(phi_reg[k]) <<< M_W) + DET_W'(plo_reg[k]);
            end
            det6_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            dneg7_reg <= det6_reg[DET_W-1];
            dmag7_reg <= DMAG_W'(det_abs);
            aneg8_reg <= aneg7_reg;
            dmag8_reg <= dmag7_reg;
            dneg8_reg <= dneg7_reg;
            sts8_reg  <= sing ? STS_SINGULAR : (range_hit ? STS_RANGE : STS_OK);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            item.m[k]       = m8_reg[k];
            item.adj_mag[k] = amag8_reg[k];
        end
        item.adj_neg = aneg8_reg;
        item.det_mag = dmag8_reg;
        item.det_neg = dneg8_reg;
        item.status  = sts8_reg;
    end

endmodule

[rtl/core/cmir_fifo.sv]
// Two-entry queue between the front pipeline and the back sequencer.
// Depends on cmir_pkg.
module cmir_fifo import cmir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmir_item_t din,
    output logic       full,
    input  logic       pop,
    output cmir_item_t dout,
    output logic       empty
);

    cmir_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/core/cmir_back.sv]
// Back sequencer: per-element scaling, restoring division, rounding, output register.
// Depends on cmir_pkg; reads cmir_fifo.
module cmir_back import cmir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  cmir_item_t         q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [IDX_W-1:0]   element_index,
    output logic [Q_W-1:0]     inverse_numerator,
    output logic [M_W-1:0]     forward_numerator,
    output cmir_status_t       status,
    output logic               last_of_run
);

    localparam int PR_W = M_W + SCALE_W;
    localparam int FS_W = (PR_W + 1 > FRAC_BITS + M_W) ? PR_W + 1 : FRAC_BITS + M_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_PREP = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    cmir_item_t         item_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [4:0]         cnt_reg;
    logic [PR_W-1:0]    plo_reg, phi_reg, fprod_reg;
    logic [SADJ_W-1:0]  sadj_reg;
    logic [DIV_W-1:0]   rem_reg, dsr_reg;
    logic [Q_W-1:0]     q_reg;
    logic [M_W-1:0]     fwd_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   idx_out_reg;
    logic [Q_W-1:0]     inv_out_reg;
    logic [M_W-1:0]     fwd_out_reg;
    cmir_status_t       sts_out_reg;
    logic               last_out_reg;

    logic               out_free;
    logic               emit;
    logic               is_last;
    logic [AMAG_W-1:0]  cur_mag;
    logic [M_W-1:0]     m_cur, m_mag;
    logic               ge;
    logic [FS_W-1:0]    fsum;
    logic               inv_neg;

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = (state_reg == ST_EMIT) && out_free;
    assign is_last  = (item_reg.status != STS_OK) || (idx_reg == IDX_W'(NUM_ELEM - 1));
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign cur_mag  = item_reg.adj_mag[idx_reg];
    assign m_cur    = item_reg.m[idx_reg];
    assign m_mag    = m_cur[M_W-1] ? (~m_cur + 1'b1) : m_cur;
    assign ge       = dsr_reg <= rem_reg;
    assign fsum     = FS_W'(fprod_reg) + (FS_W'(1) << (FRAC_BITS - 1));
    assign inv_neg  = item_reg.adj_neg[idx_reg] ^ item_reg.det_neg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_head.status != STS_OK) ? ST_EMIT : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = is_last ? ST_IDLE : ST_MUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                idx_reg <= '0;
            end
            else if (emit && !is_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_head;
        end
        if (state_reg == ST_MUL)
        begin
            plo_reg   <= cur_mag[M_W-1:0] * DENOM_SCALE;
            phi_reg   <= cur_mag[AMAG_W-1:M_W] * DENOM_SCALE;
            fprod_reg <= m_mag * DENOM_SCALE;
        end
        if (state_reg == ST_SUM)
        begin
            sadj_reg <= SADJ_W'(plo_reg) + (SADJ_W'(phi_reg) << M_W);
            fwd_reg  <= fsum[FRAC_BITS +: M_W];
        end
        if (state_reg == ST_PREP)
        begin
            // round(N/d) = floor((2N + d) / 2d), divisor pre-shifted by 31
            rem_reg <= (DIV_W'(sadj_reg) << (FRAC_BITS + 1)) + DIV_W'(item_reg.det_mag);
            dsr_reg <= DIV_W'(item_reg.det_mag) << (Q_W);
            cnt_reg <= 5'd31;
            q_reg   <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], ge};
            dsr_reg <= dsr_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (emit)
        begin
            last_out_reg <= is_last;
            sts_out_reg  <= item_reg.status;
            if (item_reg.status != STS_OK)
            begin
                idx_out_reg <= '0;
                inv_out_reg <= '0;
                fwd_out_reg <= '0;
            end
            else
            begin
                idx_out_reg <= idx_reg;
                inv_out_reg <= inv_neg ? -q_reg : q_reg;
                fwd_out_reg <= m_cur[M_W-1] ? -fwd_reg : fwd_reg;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign element_index     = idx_out_reg;
    assign inverse_numerator = inv_out_reg;
    assign forward_numerator = fwd_out_reg;
    assign status            = sts_out_reg;
    assign last_of_run       = last_out_reg;

endmodule

[rtl/core/color_matrix_inverse_rational.sv]
// Top level of the 3x3 colour matrix inverse with rational output encoding.
// Depends on cmir_pkg, cmir_front, cmir_fifo, cmir_back.
//
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | mat_r0c0 .. mat_r2c2
// output  | out_valid / out_ready| element_index, inverse_numerator, forward_numerator,
//         |                      | status, last_of_run
//
// Front: 8-stage pipeline, one matrix per cycle unless a full queue stalls it, then a 2-entry queue.
// Back: per element, states MUL, SUM, PREP, a 32-step restoring divider (DIV) and EMIT;
// a singular or out-of-range matrix goes from IDLE straight to EMIT for one failure transfer.
// Reset clears control only; no clearing pass.
// Output stall holds the back; the queue filling stalls the front.
module color_matrix_inverse_rational import cmir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] mat_r0c0,
    input  logic signed [31:0] mat_r0c1,
    input  logic signed [31:0] mat_r0c2,
    input  logic signed [31:0] mat_r1c0,
    input  logic signed [31:0] mat_r1c1,
    input  logic signed [31:0] mat_r1c2,
    input  logic signed [31:0] mat_r2c0,
    input  logic signed [31:0] mat_r2c1,
    input  logic signed [31:0] mat_r2c2,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         element_index,
    output logic signed [31:0] inverse_numerator,
    output logic signed [31:0] forward_numerator,
    output logic [1:0]         status,
    output logic               last_of_run
);

    logic [NUM_ELEM-1:0][M_W-1:0] mat_all;
    cmir_item_t                   f_item, q_head;
    logic                         push, q_full, q_empty, q_pop;
    cmir_status_t                 sts;
    logic [Q_W-1:0]               inv_u;
    logic [M_W-1:0]               fwd_u;

    assign mat_all[0] = mat_r0c0;
    assign mat_all[1] = mat_r0c1;
    assign mat_all[2] = mat_r0c2;
    assign mat_all[3] = mat_r1c0;
    assign mat_all[4] = mat_r1c1;
    assign mat_all[5] = mat_r1c2;
    assign mat_all[6] = mat_r2c0;
    assign mat_all[7] = mat_r2c1;
    assign mat_all[8] = mat_r2c2;

    cmir_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mat_in   (mat_all),
        .q_full   (q_full),
        .push     (push),
        .item     (f_item)
    );

    cmir_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (f_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    cmir_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_head            (q_head),
        .q_pop             (q_pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .element_index     (element_index),
        .inverse_numerator (inv_u),
        .forward_numerator (fwd_u),
        .status            (sts),
        .last_of_run       (last_of_run)
    );

    assign status            = sts;
    assign inverse_numerator = $signed(inv_u);
    assign forward_numerator = $signed(fwd_u);

    a_fail_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STS_OK |-> last_of_run && element_index == 4'd0)
        else $error("failure result not a single final transfer");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_OK |-> last_of_run == (element_index == 4'd8))
        else $error("last_of_run misplaced");

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty) && !(push && q_full) && !(q_pop && q_empty))
        else $error("queue overrun or underrun");

endmodule

[verif/testbench.sv]
// Self-checking testbench for color_matrix_inverse_rational.
// It sends directed and random 3x3 matrices, predicts the inverse and forward numerators,
// and checks every result transfer. Depends on cmir_pkg and the block RTL.
module testbench import cmir_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [31:0] mat_t [9];

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] inv;
        logic signed [31:0] fwd;
        cmir_status_t       sts;
        logic               last;
    } elem_res_t;

    class inverse_scoreboard;
        elem_res_t pending[$];
        int        mismatches;

        function void note_matrix(mat_t a);
            logic signed [127:0] mm [9];
            logic signed [127:0] cof [9];
            logic signed [127:0] det;
            logic [255:0]        dmag;
            logic [255:0]        amag;
            logic [255:0]        q;
            logic [255:0]        fm;
            cmir_status_t        sts;
            elem_res_t           r;
            for (int k = 0; k < 9; k++)
                mm[k] = a[k];
            cof[0] = mm[4] * mm[8] - mm[5] * mm[7];
            cof[1] = mm[2] * mm[7] - mm[1] * mm[8];
            cof[2] = mm[1] * mm[5] - mm[2] * mm[4];
            cof[3] = mm[5] * mm[6] - mm[3] * mm[8];
            cof[4] = mm[0] * mm[8] - mm[2] * mm[6];
            cof[5] = mm[2] * mm[3] - mm[0] * mm[5];
            cof[6] = mm[3] * mm[7] - mm[4] * mm[6];
            cof[7] = mm[1] * mm[6] - mm[0] * mm[7];
            cof[8] = mm[0] * mm[4] - mm[1] * mm[3];
            det = mm[0] * cof[0] + mm[1] * cof[3] + mm[2] * cof[6];
            dmag = (det < 0) ? 256'(-det) : 256'(det);
            sts = STS_OK;
            if (dmag * 256'd1000000000000 <= (256'd1 << (3 * FRAC_BITS)))
                sts = STS_SINGULAR;
            else
            begin
                for (int k = 0; k < 9; k++)
                begin
                    amag = (cof[k] < 0) ? 256'(-cof[k]) : 256'(cof[k]);
                    if ((amag << FRAC_BITS) > (dmag << INV_LIMIT_LOG2))
                        sts = STS_RANGE;
                end
            end
            if (sts != STS_OK)
            begin
                r = '{idx: 4'd0, inv: 32'sd0, fwd: 32'sd0, sts: sts, last: 1'b1};
                pending.insert(pending.size(), r);
                return;
            end
            for (int k = 0; k < 9; k++)
            begin
                amag = (cof[k] < 0) ? 256'(-cof[k]) : 256'(cof[k]);
                q = (((amag << FRAC_BITS) * 256'd10000000) * 2 + dmag) / (dmag * 2);
                fm = ((mm[k] < 0) ? 256'(-mm[k]) : 256'(mm[k])) * 256'd10000000;
                fm = (fm + (256'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r.idx  = 4'(k);
                r.inv  = ((cof[k] < 0) != (det < 0)) ? -q[31:0] : q[31:0];
                r.fwd  = (mm[k] < 0) ? -fm[31:0] : fm[31:0];
                r.sts  = STS_OK;
                r.last = (k == 8);
                pending.insert(pending.size(), r);
            end
        endfunction

        function void check_result(elem_res_t got);
            elem_res_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: idx %0d inv %0d fwd %0d sts %0d last %0b",
                             got.idx, got.inv, got.fwd, got.sts, got.last);
                return;
            end
            exp_r = pending.pop_front();
            if (got.idx != exp_r.idx || got.inv != exp_r.inv || got.fwd != exp_r.fwd
                || got.sts != exp_r.sts || got.last != exp_r.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: exp idx %0d inv %0d fwd %0d sts %0d last %0b",
                             exp_r.idx, exp_r.inv, exp_r.fwd, exp_r.sts, exp_r.last);
                    $display("          got idx %0d inv %0d fwd %0d sts %0d last %0b",
                             got.idx, got.inv, got.fwd, got.sts, got.last);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] mat [9];
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         element_index;
    logic signed [31:0] inverse_numerator;
    logic signed [31:0] forward_numerator;
    logic [1:0]         status;
    logic               last_of_run;

    inverse_scoreboard sb = new();
    int unsigned       cycles = 0;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    initial
        for (int k = 0; k < 9; k++)
            mat[k] = 32'sd0;

    always #10 clk = ~clk;

    color_matrix_inverse_rational dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mat_r0c0(mat[0]), .mat_r0c1(mat[1]), .mat_r0c2(mat[2]),
        .mat_r1c0(mat[3]), .mat_r1c1(mat[4]), .mat_r1c2(mat[5]),
        .mat_r2c0(mat[6]), .mat_r2c1(mat[7]), .mat_r2c2(mat[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .element_index(element_index), .inverse_numerator(inverse_numerator),
        .forward_numerator(forward_numerator), .status(status),
        .last_of_run(last_of_run)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_matrix(mat_t a, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int k = 0; k < 9; k++)
            mat[k] <= a[k];
        do @(posedge clk); while (!in_ready);
        sb.note_matrix(a);
    endtask

    function automatic mat_t diag3(logic signed [31:0] a, logic signed [31:0] b,
                                   logic signed [31:0] c);
        mat_t r;
        for (int k = 0; k < 9; k++)
            r[k] = 32'sd0;
        r[0] = a;
        r[4] = b;
        r[8] = c;
        return r;
    endfunction

    function automatic mat_t random_matrix();
        mat_t r;
        int   kind;
        int   mag;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
        begin
            case (kind)
                6: r[k] = $urandom;
                8: r[k] = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
                9: r[k] = (k % 4 == 0) ? $signed($urandom_range(1, 4096)) : 32'sd0;
                default:
                begin
                    if (k % 4 == 0)
                    begin
                        mag = $urandom_range(1 << 22, 1 << 30);
                        r[k] = $urandom_range(0, 1) ? -mag : mag;
                    end
                    else
                        r[k] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
                end
            endcase
        end
        if (kind == 7)
            for (int k = 0; k < 3; k++)
                r[6 + k] = r[k];
        return r;
    endfunction

    initial
    begin
        mat_t dir [$];
        mat_t t;
        bit   burst;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        dir.insert(dir.size(), diag3(32'sd16777216, 32'sd16777216, 32'sd16777216));
        dir.insert(dir.size(), diag3(32'sd0, 32'sd0, 32'sd0));
        dir.insert(dir.size(), diag3(32'sd1, 32'sd1, 32'sd1));
        dir.insert(dir.size(), diag3(32'sd131072, 32'sd131072, 32'sd131072));
        dir.insert(dir.size(), diag3(-32'sd131072, 32'sd131072, -32'sd131072));
        dir.insert(dir.size(), diag3(32'sd131071, 32'sd16777216, 32'sd16777216));
        dir.insert(dir.size(), diag3(32'h7fffffff, 32'sh80000000, 32'h7fffffff));
        dir.insert(dir.size(), diag3(32'sh80000000, 32'sh80000000, 32'sh80000000));
        dir.insert(dir.size(), diag3(-32'sd16777216, 32'sd8388608, 32'sd33554432));
        for (int k = 0; k < 9; k++)
            t[k] = 32'h7fffffff;
        dir.insert(dir.size(), t);
        for (int k = 0; k < 9; k++)
            t[k] = 32'sh80000000;
        dir.insert(dir.size(), t);
        t = diag3(32'h7fffffff, 32'h7fffffff, 32'sh80000000);
        t[1] = 32'sh80000000;
        t[5] = 32'h7fffffff;
        t[6] = 32'sh80000000;
        dir.insert(dir.size(), t);
        t = diag3(32'sd8, 32'sd5, 32'sd16777216);
        t[1] = 32'sd3;
        t[3] = 32'sd3;
        dir.insert(dir.size(), t);
        t = diag3(32'sd16777216, 32'sd16777216, 32'sd16777216);
        t[1] = 32'sd16777215;
        t[3] = 32'sd16777216;
        dir.insert(dir.size(), t);

        foreach (dir[i])
            send_matrix(dir[i], $urandom_range(0, 5));

        burst = 1'b0;
        for (int i = 0; i < 120; i++)
        begin
            if (i % 16 == 0)
                burst = $urandom_range(0, 2) == 0;
            if (i == 60)
            begin
                in_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            send_matrix(random_matrix(), burst ? 0 : $urandom_range(0, 5));
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        int        stall;
        bit        burst;
        elem_res_t got;
        burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                burst = ~burst;
            stall = burst ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.idx  = element_index;
            got.inv  = inverse_numerator;
            got.fwd  = forward_numerator;
            got.sts  = cmir_status_t'(status);
            got.last = last_of_run;
            sb.check_result(got);
        end
    end
endmodule
